/* sv/differential_pd_motor_drive_unit_assert.svh */
// Assertion macros for the differential PD motor drive unit.
`ifndef DIFFERENTIAL_PD_MOTOR_DRIVE_UNIT_ASSERT_SVH
`define DIFFERENTIAL_PD_MOTOR_DRIVE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// prop is a full property expression, clocked on clk, held off during reset
`define DPMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// cond must never be true at a clock edge
`define DPMD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DPMD_ASSERT(lbl, prop, msg)
`define DPMD_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/dpmd_pkg.sv */
// Types and constants shared by the differential PD motor drive unit.
package dpmd_pkg;

	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CMP_W     = 12;
	localparam int PD_W      = 16;          // PD output, signed Q.8, +/-100.0
	localparam int DUTY_W    = PD_W + 1;    // straight +/- turn

	localparam int PD_LIMIT_Q8    = 25600;
	localparam int PD_LIMIT_Q16   = PD_LIMIT_Q8 * 256;
	localparam int DUTY_LIMIT_Q8  = 25344;
	localparam int PWM_SCALE      = 30;

	localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(2999);
	localparam logic [CMP_W-1:0] CMP_MIN = CMP_W'(29);

	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_P = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_D = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_P     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_D     = CFG_IDX_W'(3);

	localparam logic [GAIN_W-1:0] STRAIGHT_P_RST = GAIN_W'(205);
	localparam logic [GAIN_W-1:0] STRAIGHT_D_RST = GAIN_W'(512);
	localparam logic [GAIN_W-1:0] TURN_P_RST     = GAIN_W'(1024);
	localparam logic [GAIN_W-1:0] TURN_D_RST     = GAIN_W'(1280);

	// stage load enables handed to the per-axis datapath
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctrl_t;

endpackage

/* sv/dpmd_pd_axis.sv */
// One PD axis: gain products in stage 2, saturated Q.8 sum in stage 3.
module dpmd_pd_axis #(
	parameter int ERR_W = 22
) (
	input  logic                              clk,
	input  dpmd_pkg::pipe_ctrl_t              ctrl,
	input  logic        [dpmd_pkg::GAIN_W-1:0] kp,
	input  logic        [dpmd_pkg::GAIN_W-1:0] kd,
	input  logic signed [ERR_W-1:0]           err,
	input  logic signed [ERR_W:0]             derr,
	output logic signed [dpmd_pkg::PD_W-1:0]  pd
);
	import dpmd_pkg::*;

	localparam int PW  = ERR_W + GAIN_W + 1;
	localparam int QW  = ERR_W + GAIN_W + 2;
	localparam int SW  = QW + 1;
	localparam int SAT_W = 24;

	logic signed [PW-1:0]    prod_p_s2;
	logic signed [QW-1:0]    prod_d_s2;
	logic signed [PW-1:0]    prod_p;
	logic signed [QW-1:0]    prod_d;
	logic signed [SW-1:0]    sum;
	logic signed [SAT_W-1:0] sat;
	logic signed [SAT_W-1:0] sat_adj;
	logic signed [PD_W-1:0]  pd_s3;

	assign prod_p = PW'($signed({1'b0, kp})) * PW'(err);
	assign prod_d = QW'($signed({1'b0, kd})) * QW'(derr);

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			prod_p_s2 <= prod_p;
			prod_d_s2 <= prod_d;
		end
	end

	assign sum = SW'(prod_p_s2) + SW'(prod_d_s2);

	always_comb begin
		if (sum > SW'(PD_LIMIT_Q16))
			sat = SAT_W'(PD_LIMIT_Q16);
		else if (sum < -SW'(PD_LIMIT_Q16))
			sat = -SAT_W'(PD_LIMIT_Q16);
		else
			sat = sum[SAT_W-1:0];
		// truncate toward zero when dropping the low byte
		sat_adj = sat + (sat[SAT_W-1] ? SAT_W'(255) : SAT_W'(0));
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3)
			pd_s3 <= sat_adj[SAT_W-1:8];
	end

	assign pd = pd_s3;

endmodule

/* sv/dpmd_drive_side.sv */
// One motor side: duty clamp, direction enables and PWM compare value.
module dpmd_drive_side (
	input  logic signed [dpmd_pkg::DUTY_W-1:0] duty,
	output logic                               fwd,
	output logic                               rev,
	output logic        [dpmd_pkg::CMP_W-1:0]  cmp
);
	import dpmd_pkg::*;

	localparam int MAG_W  = 15;
	localparam int PROD_W = 20;

	logic signed [DUTY_W-1:0] clamped;
	logic        [MAG_W-1:0]  mag;
	logic        [MAG_W-1:0]  headroom;
	logic        [PROD_W-1:0] scaled;

	always_comb begin
		if (duty > DUTY_W'(DUTY_LIMIT_Q8))
			clamped = DUTY_W'(DUTY_LIMIT_Q8);
		else if (duty < -DUTY_W'(DUTY_LIMIT_Q8))
			clamped = -DUTY_W'(DUTY_LIMIT_Q8);
		else
			clamped = duty;
		mag      = clamped[DUTY_W-1] ? MAG_W'(-clamped) : MAG_W'(clamped);
		headroom = MAG_W'(PD_LIMIT_Q8) - mag;
		// 30*x as 32x - 2x, then minus one; fits 20 bits
		scaled   = (PROD_W'(headroom) << 5) - (PROD_W'(headroom) << 1) - PROD_W'(1);
	end

	assign fwd = !clamped[DUTY_W-1];
	assign rev = clamped[DUTY_W-1] || (clamped == '0);
	assign cmp = scaled[PROD_W-1:8];

endmodule

/* sv/differential_pd_motor_drive_unit.sv */
// Top level of the differential PD motor drive unit.
//
// One input beat per control tick: straight_target, straight_measured and
// heading_error, all signed Q.8. One output beat per tick: direction enables
// and a 3000-count PWM compare value for each side; zero duty gives a brake
// (both enables set, compare 2999).
// Gains are written over the cfg port (index 0..3; higher indexes are
// ignored). cfg_ready is always high; write only while no beat is in flight.
// Pipeline: input stage (errors and differences), gain products, saturated
// PD sums, output register. One beat can be taken every cycle while
// in_stall is low.
// Each stage moves up when the stage after it is empty or moving, so the
// unit keeps taking input beats while results wait under out_stall until
// all four stages are full; then in_stall rises.
// Reset clears the gains to their defaults, the previous-error state to zero
// and all stage valids.
`include "differential_pd_motor_drive_unit_assert.svh"

module differential_pd_motor_drive_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [20:0]                    straight_target,
	input  logic signed [20:0]                    straight_measured,
	input  logic signed [16:0]                    heading_error,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  left_forward,
	output logic                                  left_reverse,
	output logic                                  right_forward,
	output logic                                  right_reverse,
	output logic        [dpmd_pkg::CMP_W-1:0]     left_compare,
	output logic        [dpmd_pkg::CMP_W-1:0]     right_compare,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [dpmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [dpmd_pkg::GAIN_W-1:0]    cfg_data
);
	import dpmd_pkg::*;

	localparam int SE_W = 22;
	localparam int HE_W = 17;

	logic [GAIN_W-1:0] straight_p_q;
	logic [GAIN_W-1:0] straight_d_q;
	logic [GAIN_W-1:0] turn_p_q;
	logic [GAIN_W-1:0] turn_d_q;

	logic signed [SE_W-1:0] last_straight_q;
	logic signed [HE_W-1:0] last_heading_q;

	logic signed [SE_W-1:0] serr;
	logic signed [SE_W-1:0] serr_s1;
	logic signed [SE_W:0]   dserr_s1;
	logic signed [HE_W-1:0] head_s1;
	logic signed [HE_W:0]   dhead_s1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s4;
	pipe_ctrl_t ctrl;
	logic in_beat;

	logic signed [PD_W-1:0]   s_pd, t_pd;
	logic signed [DUTY_W-1:0] left_duty, right_duty;
	logic l_fwd, l_rev, r_fwd, r_rev;
	logic [CMP_W-1:0] l_cmp, r_cmp;

	// stage enables: a stage loads when the next one is empty or loading
	assign en_s4      = !v_s4 || !out_stall;
	assign ctrl.en_s3 = !v_s3 || en_s4;
	assign ctrl.en_s2 = !v_s2 || ctrl.en_s3;
	assign en_s1      = !v_s1 || ctrl.en_s2;
	assign in_stall   = !en_s1;
	assign in_beat    = in_valid && en_s1;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_p_q <= STRAIGHT_P_RST;
			straight_d_q <= STRAIGHT_D_RST;
			turn_p_q     <= TURN_P_RST;
			turn_d_q     <= TURN_D_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STRAIGHT_P: straight_p_q <= cfg_data;
				REG_STRAIGHT_D: straight_d_q <= cfg_data;
				REG_TURN_P:     turn_p_q     <= cfg_data;
				REG_TURN_D:     turn_d_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign serr = SE_W'(straight_target) - SE_W'(straight_measured);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_straight_q <= '0;
			last_heading_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_beat) begin
				last_straight_q <= serr;
				last_heading_q  <= heading_error;
			end
			if (en_s1)      v_s1 <= in_valid;
			if (ctrl.en_s2) v_s2 <= v_s1;
			if (ctrl.en_s3) v_s3 <= v_s2;
			if (en_s4)      v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			serr_s1  <= serr;
			dserr_s1 <= (SE_W + 1)'(serr) - (SE_W + 1)'(last_straight_q);
			head_s1  <= heading_error;
			dhead_s1 <= (HE_W + 1)'(heading_error) - (HE_W + 1)'(last_heading_q);
		end
	end

	dpmd_pd_axis #(.ERR_W(SE_W)) u_straight (
		.clk  (clk),
		.ctrl (ctrl),
		.kp   (straight_p_q),
		.kd   (straight_d_q),
		.err  (serr_s1),
		.derr (dserr_s1),
		.pd   (s_pd)
	);

	dpmd_pd_axis #(.ERR_W(HE_W)) u_turn (
		.clk  (clk),
		.ctrl (ctrl),
		.kp   (turn_p_q),
		.kd   (turn_d_q),
		.err  (head_s1),
		.derr (dhead_s1),
		.pd   (t_pd)
	);

	assign left_duty  = DUTY_W'(s_pd) - DUTY_W'(t_pd);
	assign right_duty = DUTY_W'(s_pd) + DUTY_W'(t_pd);

	dpmd_drive_side u_left (
		.duty (left_duty),
		.fwd  (l_fwd),
		.rev  (l_rev),
		.cmp  (l_cmp)
	);

	dpmd_drive_side u_right (
		.duty (right_duty),
		.fwd  (r_fwd),
		.rev  (r_rev),
		.cmp  (r_cmp)
	);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			left_forward  <= l_fwd;
			left_reverse  <= l_rev;
			right_forward <= r_fwd;
			right_reverse <= r_rev;
			left_compare  <= l_cmp;
			right_compare <= r_cmp;
		end
	end

	assign out_valid = v_s4;

	// input backs up only when every stage holds a beat and the output is stalled
	`DPMD_ASSERT(a_stall_only_full, in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid && out_stall), "in_stall with room in pipe")
	`DPMD_NEVER(a_dir_both_off, out_valid && !left_forward && !left_reverse, "left enables both low")
	`DPMD_ASSERT(a_brake_cmp, (out_valid && right_forward && right_reverse) |-> (right_compare == CMP_MAX), "brake without full compare")
	`DPMD_ASSERT(a_cmp_range, out_valid |-> (left_compare >= CMP_MIN && left_compare <= CMP_MAX), "left compare out of range")
	`DPMD_ASSERT(a_state_track, in_beat |=> (last_heading_q == $past(heading_error)), "heading state not updated")

endmodule
